FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the matrix driver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cond at every rising edge of clk, outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// Beat layouts, field widths and colour plane codes for the matrix driver.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsp_pkg;

   localparam int COLOR_W     = 12;
   localparam int NIBBLE_W    = 4;
   localparam int ROW_FIELD_W = 3;
   localparam int COL_FIELD_W = 3;
   localparam int POS_W       = 5;
   localparam int LVL_MAX_W   = 8;
   localparam int PLANE_W     = 2;

   localparam logic [PLANE_W-1:0] PLANE_GREEN = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_RED   = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_BLUE  = 2'd2;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [ROW_FIELD_W-1:0] pixel_row;
      logic [COL_FIELD_W-1:0] pixel_column;
      logic [COLOR_W-1:0]     pixel_color;
   } req_type;

   typedef struct packed {
      logic                   serial_bit;
      logic [POS_W-1:0]       bit_position;
      logic [ROW_FIELD_W-1:0] open_row;
      logic                   last_bit;
   } rsp_type;

   // One store read on its way to the output stage.
   typedef struct packed {
      logic                   valid;
      logic [PLANE_W-1:0]     plane;
      logic [POS_W-1:0]       pos;
      logic                   last;
      logic [ROW_FIELD_W-1:0] open_row;
      logic [LVL_MAX_W-1:0]   level;
   } issue_type;

endpackage

`default_nettype wire

FILE: hdl/rmsp_req_if.sv
// ----------------------------------------------------------------------------
// rmsp_req_if
// Command channel: pixel writes and refresh ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsp_req_if;
   logic              valid;
   logic              ready;
   rmsp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rmsp_rsp_if.sv
// ----------------------------------------------------------------------------
// rmsp_rsp_if
// Serial bit channel towards the column driver chain.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsp_rsp_if;
   logic              valid;
   logic              ready;
   rmsp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rmsp_ram.sv
// ----------------------------------------------------------------------------
// rmsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsp_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/rmsp_scan.sv
// ----------------------------------------------------------------------------
// rmsp_scan
// Row scan sequencer: walks plane and column for one row, one read a cycle while
// take is high; advances the scan row at each row end, the PWM level per frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rmsp_scan #(
   parameter int ROWS       = 8,
   parameter int COLUMNS    = 8,
   parameter int LEVEL_BITS = 4,
   localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                tick_start,
   input  wire logic                take,
   output      rmsp_pkg::issue_type issue,
   output      logic [ADDR_W-1:0]   rd_addr,
   output      logic                busy
);

   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int K_W   = $clog2(3 * COLUMNS);

   logic                         active_ff, active_in;
   logic [rmsp_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [K_W-1:0]               k_ff, k_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [LEVEL_BITS-1:0]        level_ff, level_in;
   logic                         fire;
   logic                         col_end;
   logic                         row_done;

   assign fire     = active_ff && take;
   assign col_end  = (col_ff == COL_W'(COLUMNS - 1));
   assign row_done = (plane_ff == rmsp_pkg::PLANE_BLUE) && col_end;

   always_comb begin
      active_in = active_ff;
      plane_in  = plane_ff;
      col_in    = col_ff;
      k_in      = k_ff;
      row_in    = row_ff;
      level_in  = level_ff;
      if (tick_start) begin
         active_in = 1'b1;
         plane_in  = rmsp_pkg::PLANE_GREEN;
         col_in    = '0;
         k_in      = '0;
      end else if (fire) begin
         k_in = k_ff + K_W'(1);
         if (row_done) begin
            active_in = 1'b0;
            // wrap the row and step the level once per frame
            if (row_ff == ROW_W'(ROWS - 1)) begin
               row_in   = '0;
               level_in = level_ff + LEVEL_BITS'(1);
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else if (col_end) begin
            col_in   = '0;
            plane_in = plane_ff + rmsp_pkg::PLANE_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         plane_ff  <= rmsp_pkg::PLANE_GREEN;
         col_ff    <= '0;
         k_ff      <= '0;
         row_ff    <= '0;
         level_ff  <= '0;
      end else begin
         active_ff <= active_in;
         plane_ff  <= plane_in;
         col_ff    <= col_in;
         k_ff      <= k_in;
         row_ff    <= row_in;
         level_ff  <= level_in;
      end
   end

   assign rd_addr = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign busy    = active_ff;

   always_comb begin
      issue          = '0;
      issue.valid    = fire;
      issue.plane    = plane_ff;
      issue.pos      = rmsp_pkg::POS_W'(k_ff);
      issue.last     = row_done;
      issue.open_row = row_done ? rmsp_pkg::ROW_FIELD_W'(row_ff) : '0;
      issue.level    = rmsp_pkg::LVL_MAX_W'(level_ff);
   end

   `ASSERT_ALWAYS(a_k_in_range, clock, reset, !active_ff || (32'(k_ff) < 3 * COLUMNS), "bit count past end of row")
   `ASSERT_NEXT(a_last_ends_row, clock, reset, fire && row_done, !active_ff, "row scan did not stop after last beat")

endmodule

`default_nettype wire

FILE: hdl/rmsp_emit.sv
// ----------------------------------------------------------------------------
// rmsp_emit
// Output stage: picks the plane nibble of the read colour, compares it with
// the PWM level and holds each serial beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rmsp_emit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rmsp_pkg::issue_type                issue,
   input  wire logic [rmsp_pkg::COLOR_W-1:0]       rd_color,
   output      logic                               take,
   rmsp_rsp_if.source                              rsp_bus
);

   logic                         b_valid_ff, b_valid_in;
   rmsp_pkg::issue_type          b_meta_ff;
   logic                         out_valid_ff, out_valid_in;
   rmsp_pkg::rsp_type            out_data_ff;
   logic                         b_move;
   logic [rmsp_pkg::NIBBLE_W-1:0] nibble;
   rmsp_pkg::rsp_type            beat;

   assign b_move = b_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign take   = !b_valid_ff || b_move;

   always_comb begin
      case (b_meta_ff.plane)
         rmsp_pkg::PLANE_GREEN: nibble = rd_color[7:4];
         rmsp_pkg::PLANE_RED:   nibble = rd_color[3:0];
         default:               nibble = rd_color[11:8];
      endcase
   end

   always_comb begin
      beat              = '0;
      beat.serial_bit   = (rmsp_pkg::LVL_MAX_W'(nibble) > b_meta_ff.level);
      beat.bit_position = b_meta_ff.pos;
      beat.open_row     = b_meta_ff.open_row;
      beat.last_bit     = b_meta_ff.last;
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (issue.valid) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (b_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         b_meta_ff <= issue;
      end
      if (b_move) begin
         out_data_ff <= beat;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;

   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(b_valid_ff && !b_move && issue.valid), "read issued into a stalled stage")

endmodule

`default_nettype wire

FILE: hdl/rgb_matrix_scan_pwm.sv
// ----------------------------------------------------------------------------
// rgb_matrix_scan_pwm
// Row-scanned RGB LED matrix driver with PWM dimming.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries commands. A pixel write (cmd 1) stores a 0x0BGR colour;
//   writes outside the matrix are dropped. A refresh tick (cmd 0) shifts
//   out 3*COLUMNS beats on rsp_bus for the current scan row: green for
//   columns 0 upwards, then red, then blue. A beat's bit is 1 when the nibble
//   exceeds the PWM level. The last beat carries last_bit and open_row.
//   A tick's first beat passes the scan active flag, the registered store read
//   and the output register before it is valid. Throughput: one beat per cycle
//   while rsp_bus takes every beat, set by the single read port of the pixel
//   store. req_bus.ready stays low while the row's reads are issued and
//   rises again once the last read is out; trailing beats still drain.
//   When rsp_bus stalls, the two output stages hold and the reads pause.
//   Reset clears scan row and level and marks every pixel dark through
//   per-entry valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_matrix_scan_pwm #(
   parameter int ROWS       = 8,
   parameter int COLUMNS    = 8,
   parameter int LEVEL_BITS = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rmsp_req_if.sink    req_bus,
   rmsp_rsp_if.source  rsp_bus
);

   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                          busy;
   logic                          accept;
   logic                          tick_start;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ADDR_W-1:0]             rd_addr;
   logic [rmsp_pkg::COLOR_W-1:0]  ram_rd_data;
   logic [rmsp_pkg::COLOR_W-1:0]  rd_color;
   logic                          take;
   rmsp_pkg::issue_type           issue;
   logic [DEPTH-1:0]              vld_ff, vld_in;
   logic                          vld_rd_ff;

   assign req_bus.ready = !busy;
   assign accept        = req_bus.valid && !busy;
   assign tick_start    = accept && (req_bus.data.cmd == rmsp_pkg::CMD_TICK);
   assign wr_en         = accept && (req_bus.data.cmd == rmsp_pkg::CMD_WRITE)
                          && (32'(req_bus.data.pixel_row) < ROWS)
                          && (32'(req_bus.data.pixel_column) < COLUMNS);
   assign wr_addr       = ADDR_W'(32'(req_bus.data.pixel_row) * COLUMNS
                                  + 32'(req_bus.data.pixel_column));

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // track the valid bit alongside the registered RAM read
   always_ff @(posedge clock) begin
      if (issue.valid) begin
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_color = vld_rd_ff ? ram_rd_data : '0;

   rmsp_ram #(
      .WIDTH (rmsp_pkg::COLOR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.data.pixel_color),
      .rd_en   (issue.valid),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   rmsp_scan #(
      .ROWS       (ROWS),
      .COLUMNS    (COLUMNS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .tick_start (tick_start),
      .take       (take),
      .issue      (issue),
      .rd_addr    (rd_addr),
      .busy       (busy)
   );

   rmsp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .rd_color (rd_color),
      .take     (take),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the row-scanned RGB matrix driver. A scripted
// opening drives pixel writes and refresh ticks with hand-read line patterns,
// then a random mix of writes and ticks runs long enough to wrap the PWM
// level. Every serial beat is checked against a line predictor, with random
// idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
   import rmsp_pkg::*;

   localparam int BEATS_PER_ROW = 24;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 30;

   typedef struct {
      req_type     item;
      bit          pinned;
      logic [23:0] lit;
   } script_row_t;

   logic clock;
   logic reset;

   rmsp_req_if req ();
   rmsp_rsp_if rsp ();

   rgb_matrix_scan_pwm uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp)
   );

   // line predictor state
   logic [11:0] colour_store [64];
   logic [2:0]  row_now;
   logic [3:0]  level_now;
   rsp_type     pending_beats [$];

   script_row_t script [$];
   bit          pin_next;
   logic [23:0] pin_lit;
   bit          calm;
   int          error_count;
   int          cycle_count;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // expand one accepted command into the beats it must produce
   task automatic apply_command(input req_type c, input bit pinned, input logic [23:0] lit);
      logic [11:0]        colour;
      logic [3:0]         nib;
      logic [PLANE_W-1:0] plane;
      rsp_type            beat;
      int                 k;
      if (c.cmd == CMD_WRITE) begin
         colour_store[{c.pixel_row, c.pixel_column}] = c.pixel_color;
      end else begin
         for (k = 0; k < BEATS_PER_ROW; k++) begin
            colour = colour_store[{row_now, k[2:0]}];
            plane  = k[4:3];
            case (plane)
               PLANE_GREEN: nib = colour[7:4];
               PLANE_RED:   nib = colour[3:0];
               default:     nib = colour[11:8];
            endcase
            beat.serial_bit   = pinned ? lit[k] : (nib > level_now);
            beat.bit_position = k[4:0];
            beat.last_bit     = (k == BEATS_PER_ROW - 1);
            beat.open_row     = beat.last_bit ? row_now : '0;
            pending_beats.push_back(beat);
         end
         row_now = row_now + 3'd1;
         if (row_now == 3'd0)
            level_now = level_now + 4'd1;
      end
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (pending_beats.size() == 0) begin
         $display("%0t: unexpected beat: expected none, got bit %0d pos %0d row %0d last %0d",
                  $time, got.serial_bit, got.bit_position, got.open_row, got.last_bit);
         error_count++;
      end else begin
         want = pending_beats.pop_front();
         if (got.serial_bit !== want.serial_bit || got.bit_position !== want.bit_position ||
             got.open_row !== want.open_row || got.last_bit !== want.last_bit) begin
            $display("%0t: beat mismatch: expected bit %0d pos %0d row %0d last %0d, got bit %0d pos %0d row %0d last %0d",
                     $time, want.serial_bit, want.bit_position, want.open_row, want.last_bit,
                     got.serial_bit, got.bit_position, got.open_row, got.last_bit);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (colour_store[i])
            colour_store[i] = '0;
         row_now   = '0;
         level_now = '0;
         pending_beats.delete();
      end else begin
         if (req.valid && req.ready)
            apply_command(req.data, pin_next, pin_lit);
         if (rsp.valid && rsp.ready)
            check_beat(rsp.data);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // sink side: random hold-off before each beat
   initial begin
      int gap;
      rsp.ready = 1'b0;
      forever begin
         gap = calm ? 0 : $urandom_range(0, 9);
         repeat (gap) begin
            @(negedge clock);
            rsp.ready = 1'b0;
         end
         @(negedge clock);
         rsp.ready = 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   task automatic send_command(input req_type c, input bit pinned, input logic [23:0] lit);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      pin_next  = pinned;
      pin_lit   = lit;
      req.data  = c;
      req.valid = 1'b1;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic add_row(input logic cmd, input logic [2:0] r, input logic [2:0] col,
                          input logic [11:0] colour, input bit pinned, input logic [23:0] lit);
      script_row_t s;
      s.item.cmd          = cmd;
      s.item.pixel_row    = r;
      s.item.pixel_column = col;
      s.item.pixel_color  = colour;
      s.pinned            = pinned;
      s.lit               = lit;
      script.push_back(s);
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      req_type c;
      int      n;
      int      pick;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.data    = '0;
      pin_next    = 1'b0;
      pin_lit     = '0;
      calm        = 1'b0;
      error_count = 0;
      cycle_count = 0;

      // fresh store: every line dark, pixel fields of a tick ignored
      add_row(CMD_TICK,  3'd5, 3'd2, 12'hABC, 1'b1, 24'h000000);
      add_row(CMD_WRITE, 3'd1, 3'd0, 12'hFFF, 1'b0, '0);
      add_row(CMD_WRITE, 3'd1, 3'd7, 12'h0F0, 1'b0, '0);
      add_row(CMD_WRITE, 3'd1, 3'd4, 12'h001, 1'b0, '0);
      add_row(CMD_TICK,  3'd7, 3'd7, 12'hFFF, 1'b1, 24'h011181);
      add_row(CMD_WRITE, 3'd2, 3'd3, 12'hF00, 1'b0, '0);
      add_row(CMD_WRITE, 3'd0, 3'd0, 12'hFFF, 1'b0, '0);
      add_row(CMD_WRITE, 3'd7, 3'd7, 12'hFFF, 1'b0, '0);
      add_row(CMD_WRITE, 3'd7, 3'd0, 12'h000, 1'b0, '0);
      add_row(CMD_WRITE, 3'd7, 3'd0, 12'h888, 1'b0, '0);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h080000);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h000000);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h000000);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h000000);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h000000);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h818181);
      // level 1 now: a nibble of 1 goes dark
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h010101);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b1, 24'h010181);
      add_row(CMD_WRITE, 3'd3, 3'd5, 12'h7A3, 1'b0, '0);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b0, '0);
      add_row(CMD_WRITE, 3'd3, 3'd2, 12'hFFF, 1'b0, '0);
      add_row(CMD_TICK,  3'd0, 3'd0, 12'h000, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i])
         send_command(script[i].item, script[i].pinned, script[i].lit);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            // hold until the matrix has shifted out everything owed
            @(negedge clock);
            req.valid = 1'b0;
            wait_drained();
         end
         calm = (n >= 200 && n < 240);
         c.cmd          = ($urandom_range(0, 9) < 6) ? CMD_TICK : CMD_WRITE;
         c.pixel_row    = 3'($urandom_range(0, 7));
         c.pixel_column = 3'($urandom_range(0, 7));
         pick = $urandom_range(0, 7);
         if (pick == 0)
            c.pixel_color = 12'hFFF;
         else if (pick == 1)
            c.pixel_color = 12'h000;
         else
            c.pixel_color = 12'($urandom);
         send_command(c, 1'b0, '0);
      end
      calm = 1'b0;
      @(negedge clock);
      req.valid = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: rgb_matrix_scan_pwm.f
+incdir+hdl
hdl/rmsp_pkg.sv
hdl/rmsp_req_if.sv
hdl/rmsp_rsp_if.sv
hdl/rmsp_ram.sv
hdl/rmsp_scan.sv
hdl/rmsp_emit.sv
hdl/rgb_matrix_scan_pwm.sv
tb/sv/tb_top.sv
